// ----- rtl/core/idmh_pkg.sv -----
package idmh_pkg;

	localparam int unsigned ID_WORDS_DEF = 5;
	localparam int unsigned WORD_W       = 32;

	localparam logic [WORD_W-1:0] MM_MAGIC = 32'h5bd1e995;

	localparam int unsigned SHIFT_K  = 24;
	localparam int unsigned SHIFT_A1 = 13;
	localparam int unsigned SHIFT_A2 = 15;

	// Multiplier operand select
	typedef enum logic [1:0] {
		OPSEL_K,
		OPSEL_H,
		OPSEL_AV
	} opsel_t;

	// Controller to datapath
	typedef struct packed {
		logic   load_word;   // capture key word
		logic   first_word;  // reload running hash from seed
		logic   step_k;      // k = k*M ^ (k*M >> 24) or k = k*M
		logic   k_xor;       // apply the shift-XOR on this k step
		logic   step_h;      // h = h*M ^ k
		logic   load_out;    // avalanche result into output register
		opsel_t opsel;
	} dp_cmd_t;

endpackage

// ----- rtl/core/idmh_dp.sv -----
module idmh_dp #(
	parameter int unsigned ID_WORDS = idmh_pkg::ID_WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  idmh_pkg::dp_cmd_t              cmd,
	input  logic [idmh_pkg::WORD_W-1:0]    key_word,
	input  logic                           cfg_we,
	input  logic [idmh_pkg::WORD_W-1:0]    cfg_data,
	output logic [idmh_pkg::WORD_W-1:0]    hash_value,
	output logic                           id_was_zero
);

	localparam logic [idmh_pkg::WORD_W-1:0] KEY_BYTES = idmh_pkg::WORD_W'(4 * ID_WORDS);

	logic [idmh_pkg::WORD_W-1:0] seed_q;
	logic [idmh_pkg::WORD_W-1:0] k_q;
	logic [idmh_pkg::WORD_W-1:0] h_q;
	logic                        zero_q;
	logic [idmh_pkg::WORD_W-1:0] hash_q;
	logic                        was_zero_q;

	logic [idmh_pkg::WORD_W-1:0] h_pre;
	logic [idmh_pkg::WORD_W-1:0] mul_a;
	logic [idmh_pkg::WORD_W-1:0] prod;
	logic [idmh_pkg::WORD_W-1:0] aval;

	// the one shared multiplier, low 32 bits kept
	assign h_pre = h_q ^ (h_q >> idmh_pkg::SHIFT_A1);

	always_comb begin
		case (cmd.opsel)
			idmh_pkg::OPSEL_K:  mul_a = k_q;
			idmh_pkg::OPSEL_H:  mul_a = h_q;
			idmh_pkg::OPSEL_AV: mul_a = h_pre;
			default:            mul_a = k_q;
		endcase
	end

	assign prod = mul_a * idmh_pkg::MM_MAGIC;
	assign aval = prod ^ (prod >> idmh_pkg::SHIFT_A2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_we) begin
			seed_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_word) begin
			k_q    <= key_word;
			zero_q <= (cmd.first_word | zero_q) & (key_word == '0);
			if (cmd.first_word) begin
				h_q <= seed_q ^ KEY_BYTES;
			end
		end
		if (cmd.step_k) begin
			k_q <= cmd.k_xor ? (prod ^ (prod >> idmh_pkg::SHIFT_K)) : prod;
		end
		if (cmd.step_h) begin
			h_q <= prod ^ k_q;
		end
		if (cmd.load_out) begin
			hash_q     <= zero_q ? '0 : aval;
			was_zero_q <= zero_q;
		end
	end

	assign hash_value  = hash_q;
	assign id_was_zero = was_zero_q;

endmodule

// ----- rtl/core/idmh_ctrl.sv -----
module idmh_ctrl #(
	parameter int unsigned ID_WORDS = idmh_pkg::ID_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output idmh_pkg::dp_cmd_t cmd
);

	localparam int unsigned CNT_W = (ID_WORDS > 1) ? $clog2(ID_WORDS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ID_WORDS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_K1,
		ST_K2,
		ST_H,
		ST_AV
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid & in_ready;
	assign out_free  = ~out_valid_q | out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.opsel      = idmh_pkg::OPSEL_K;
		cmd.load_word  = accept;
		cmd.first_word = (cnt_q == '0);
		unique case (state_q)
			ST_IDLE: ;
			ST_K1: begin
				cmd.step_k = 1'b1;
				cmd.k_xor  = 1'b1;
			end
			ST_K2: cmd.step_k = 1'b1;
			ST_H: begin
				cmd.step_h = 1'b1;
				cmd.opsel  = idmh_pkg::OPSEL_H;
			end
			ST_AV: begin
				cmd.load_out = out_free;
				cmd.opsel    = idmh_pkg::OPSEL_AV;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_AV && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_K1;
				ST_K1:   state_q <= ST_K2;
				ST_K2:   state_q <= ST_H;
				ST_H: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_AV;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_AV: begin
					// hold the finished hash until the output register frees up
					if (out_free) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LAST)
		else $error("word count past identifier length");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second word taken while mixing");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result overwrote an untaken word");

	a_out_from_av: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_AV))
		else $error("result raised outside avalanche");

	a_av_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_H && cnt_q == CNT_LAST) |=> state_q == ST_AV)
		else $error("last word did not enter avalanche");

endmodule

// ----- rtl/core/id_murmur2_hash.sv -----
// channel   dir  handshake             payload
// s_*       in   s_tvalid / s_tready   s_tdata = key_word
// m_*       out  m_tvalid / m_tready   m_tdata = hash_value, m_tuser = id_was_zero
// cfg_*     in   cfg_valid / cfg_ready cfg_data = hash_seed
//
// Each key word passes in turn through the one shared 32x32 multiplier
// (k*M, k*M again, h*M), and the next word is taken only once the last is done;
// the last word of an identifier adds an avalanche step.
// Reset clears the seed to 0 and starts a new identifier.
// A finished hash waits in the output register; the next identifier's words are
// taken meanwhile, and only the next avalanche stalls until m_tready.
module id_murmur2_hash #(
	parameter int unsigned ID_WORDS = idmh_pkg::ID_WORDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [idmh_pkg::WORD_W-1:0] s_tdata,   // [31:0] key_word
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [idmh_pkg::WORD_W-1:0] m_tdata,   // [31:0] hash_value
	output logic [0:0]                  m_tuser,   // [0] id_was_zero
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [idmh_pkg::WORD_W-1:0] cfg_data   // [31:0] hash_seed
);

	idmh_pkg::dp_cmd_t cmd;
	logic              was_zero;

	assign cfg_ready  = 1'b1;
	assign m_tuser[0] = was_zero;

	idmh_ctrl #(
		.ID_WORDS (ID_WORDS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	idmh_dp #(
		.ID_WORDS (ID_WORDS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.key_word    (s_tdata),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_data    (cfg_data),
		.hash_value  (m_tdata),
		.id_was_zero (was_zero)
	);

endmodule

// ----- bench/tb_id_murmur2_hash.sv -----
module tb_id_murmur2_hash;

	localparam int unsigned ID_WORDS  = idmh_pkg::ID_WORDS_DEF;
	localparam logic [31:0] KEY_BYTES = 4 * ID_WORDS;
	// one identifier's processing time, with margin on top
	localparam int          SETTLE    = 4 * ID_WORDS + 10;

	typedef struct {
		logic [31:0] hash_value;
		logic        id_was_zero;
	} hash_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;    // [31:0] key_word
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;    // [31:0] hash_value
	logic [0:0]  m_tuser;    // [0] id_was_zero
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;   // [31:0] hash_seed

	hash_result_t expected_hashes[$];

	// predictor state
	logic [31:0] seed_reg;
	logic [31:0] run_hash;
	logic        id_zero;
	int          words_in_id;

	int errors;
	int hashes_checked;
	int zero_ids;
	int seeds_written;
	int words_sent;

	bit gaps_on;
	int burst_left;
	int ready_mode;
	int ready_run;

	id_murmur2_hash uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic void hash_absorb(input logic [31:0] k);
		logic [31:0] m;
		logic [31:0] h;
		if (words_in_id == 0) begin
			run_hash = seed_reg ^ KEY_BYTES;
			id_zero  = 1'b1;
		end
		if (k != 0)
			id_zero = 1'b0;
		m = k * idmh_pkg::MM_MAGIC;
		m = m ^ (m >> idmh_pkg::SHIFT_K);
		m = m * idmh_pkg::MM_MAGIC;
		run_hash = (run_hash * idmh_pkg::MM_MAGIC) ^ m;
		words_in_id++;
		if (words_in_id == ID_WORDS) begin
			h = run_hash ^ (run_hash >> idmh_pkg::SHIFT_A1);
			h = h * idmh_pkg::MM_MAGIC;
			h = h ^ (h >> idmh_pkg::SHIFT_A2);
			expected_hashes.push_back('{id_zero ? 32'h0 : h, id_zero});
			if (id_zero)
				zero_ids++;
			words_in_id = 0;
		end
	endfunction

	// receiver: ready pattern held for random runs
	always @(posedge clk) begin
		if (ready_run > 0) begin
			ready_run--;
		end else begin
			case (ready_mode)
				0: begin
					m_tready <= 1'b1;
				end
				1: begin
					m_tready  <= $urandom_range(0, 1);
					ready_run  = $urandom_range(0, 3);
				end
				default: begin
					// long stalls, short ready windows
					if (m_tready) begin
						m_tready  <= 1'b0;
						ready_run  = $urandom_range(2, 24);
					end else begin
						m_tready  <= 1'b1;
						ready_run  = $urandom_range(0, 4);
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		hash_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_hashes.size() == 0) begin
				report($sformatf("unexpected hash word %08h zero=%0d", m_tdata, m_tuser[0]));
			end else begin
				exp_r = expected_hashes.pop_front();
				hashes_checked++;
				if (m_tdata !== exp_r.hash_value)
					report($sformatf("hash_value %08h, expected %08h",
						m_tdata, exp_r.hash_value));
				if (m_tuser[0] !== exp_r.id_was_zero)
					report($sformatf("id_was_zero %0d, expected %0d",
						m_tuser[0], exp_r.id_was_zero));
			end
		end
	end

	task automatic send_key_word(input logic [31:0] w);
		if (gaps_on && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		do @(posedge clk); while (!s_tready);
		hash_absorb(w);
		if (burst_left > 0)
			burst_left--;
		words_sent++;
	endtask

	// stop sending, let every result drain and the datapath go quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_hashes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		seed_reg = v;
		seeds_written++;
	endtask

	function automatic logic [31:0] rand_key_word();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			2: return 32'h1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_reset_seed();
		gaps_on    = 0;
		ready_mode = 0;
		send_key_word(32'h0000_0001);
		send_key_word(32'h8000_0000);
		send_key_word(32'hffff_ffff);
		send_key_word(32'h1234_5678);
		send_key_word(32'h0000_0000);
		drain();
	endtask

	task automatic test_zero_id();
		repeat (ID_WORDS) send_key_word(32'h0);
		drain();
	endtask

	task automatic test_seed_extremes();
		write_seed(32'hffff_ffff);
		repeat (ID_WORDS) send_key_word(32'hffff_ffff);
		drain();
	endtask

	// seed changed between words: only the next identifier sees it
	task automatic test_seed_midstream();
		send_key_word(32'hdead_beef);
		send_key_word(32'h0000_00ff);
		drain();
		write_seed(32'h0000_0000);
		repeat (ID_WORDS - 2) send_key_word($urandom);
		repeat (ID_WORDS) send_key_word($urandom);
		drain();
	endtask

	task automatic test_random_stream(input logic [31:0] seed_v, input int n_ids,
			input bit use_gaps, input int rmode);
		int kind;
		int hot;
		write_seed(seed_v);
		gaps_on    = use_gaps;
		burst_left = 0;
		ready_mode = rmode;
		repeat (n_ids) begin
			kind = $urandom_range(0, 9);
			hot  = $urandom_range(0, ID_WORDS - 1);
			for (int i = 0; i < ID_WORDS; i++) begin
				if (kind == 0)
					send_key_word(32'h0);
				else if (kind == 1)
					send_key_word(i == hot ? rand_key_word() | 32'h1 : 32'h0);
				else
					send_key_word(rand_key_word());
			end
		end
		drain();
	endtask

	initial begin : limit
		#2_000_000;
		$display("id_murmur2_hash test failed");
		$finish;
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		seed_reg       = '0;
		run_hash       = KEY_BYTES;
		id_zero        = 1'b1;
		words_in_id    = 0;
		errors         = 0;
		hashes_checked = 0;
		zero_ids       = 0;
		seeds_written  = 0;
		words_sent     = 0;
		gaps_on        = 0;
		burst_left     = 0;
		ready_mode     = 0;
		ready_run      = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE) @(posedge clk);

		test_reset_seed();
		test_zero_id();
		test_seed_extremes();
		test_seed_midstream();
		test_random_stream(32'h0000_0000, 30, 1, 1);
		test_random_stream(32'hffff_ffff, 30, 0, 0);
		test_random_stream($urandom, 40, 1, 2);
		test_random_stream($urandom, 40, 1, 1);

		if (expected_hashes.size() != 0)
			report($sformatf("%0d hash words never arrived", expected_hashes.size()));

		$display("Sent %0d key words, checked %0d hashes (%0d all-zero identifiers),",
			words_sent, hashes_checked, zero_ids);
		$display("over %0d seed writes with gapped and stalled traffic.", seeds_written);
		if (errors == 0) begin
			$display("id_murmur2_hash test passed");
		end else begin
			$display("id_murmur2_hash test failed");
		end
		$finish;
	end

endmodule
